// File: rtl/cbyp_pkg.sv
// ----------------------------------------------------------------------------
// cbyp_pkg
// Shared widths, latencies and angle constants for the camera basis block.
// ----------------------------------------------------------------------------
package cbyp_pkg;

	// Field widths
	localparam int ANGLE_W  = 16;
	localparam int ANGLE_XW = ANGLE_W + 1;
	localparam int PITCH_W  = 14;
	localparam int VEC_W    = 16;

	// Fixed-point formats
	localparam int ANGLE_FRAC = 12;
	localparam int VEC_FRAC   = 14;
	localparam int SC_FRAC    = 30;
	localparam int Q30_SH     = SC_FRAC - ANGLE_FRAC;

	// Sine / cosine word: Q2.30 signed
	localparam int SC_W   = 32;
	localparam int SC_LAT = 20;

	// Angle limits in the angle format
	localparam logic signed [ANGLE_XW-1:0] PI_A        = 17'sd12868;
	localparam logic signed [ANGLE_XW-1:0] TWO_PI_A    = 17'sd25736;
	localparam logic signed [ANGLE_XW-1:0] PITCH_LIM_A = 17'sd6393;

	// Unit value of a vector component
	localparam logic [VEC_W-2:0] VEC_ONE = 15'd16384;

endpackage

// File: rtl/cbyp_sincos.sv
// ----------------------------------------------------------------------------
// cbyp_sincos
// Pipelined sine and cosine in Q2.30 of an angle in the angle format.
// Range reduction to about +-pi/4, then six truncated Taylor terms for each
// of sine and cosine, then a quarter-turn rotation. Constant divisions are
// a shift plus a reciprocal multiply that is exact over the operand range.
// ----------------------------------------------------------------------------
module cbyp_sincos (
	input  logic                               clk,
	input  logic signed [cbyp_pkg::ANGLE_W-1:0] ang,
	output logic signed [cbyp_pkg::SC_W-1:0]    sin_q30,
	output logic signed [cbyp_pkg::SC_W-1:0]    cos_q30
);
	import cbyp_pkg::*;

	localparam int NSTEP = 6;
	localparam int RW    = 34;
	localparam int T_W   = 31;
	localparam int AX_W  = 30;
	localparam int X2_W  = 30;
	localparam int N_W   = 29;
	localparam int M_W   = 31;
	localparam int SQ_W  = 2 * AX_W;
	localparam int PR_W  = T_W + X2_W;
	localparam int QM_W  = N_W + M_W;
	localparam int ACC_W = SC_W;

	// Power-of-two and odd parts of each term divisor
	localparam int STEP_SH [NSTEP] = '{1, 2, 1, 3, 1, 2};
	localparam int SIN_ODD [NSTEP] = '{3, 5, 21, 9, 55, 39};
	localparam int COS_ODD [NSTEP] = '{1, 3, 15, 7, 45, 33};

	localparam logic signed [RW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [RW-1:0] TWO_PI_Q30  = 34'sd6746518852;
	localparam logic signed [RW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [RW-1:0] QTR_PI_Q30  = 34'sd843314857;
	localparam logic signed [RW-1:0] TQTR_PI_Q30 = 34'sd2529944570;
	localparam logic [T_W-1:0]       ONE_Q30     = 31'd1073741824;
	localparam logic [SQ_W:0]        SQ_HALF     = 61'd536870912;

	typedef enum logic [1:0] {
		QD_ZERO,
		QD_POS1,
		QD_NEG1,
		QD_HALF
	} quad_t;

	typedef struct packed {
		logic            neg;
		quad_t           q;
		logic [X2_W-1:0] x2;
	} side_t;

	logic signed [RW-1:0]   ang_q30;
	logic signed [RW-1:0]   r_next;
	logic signed [RW-1:0]   r_w;
	logic signed [RW-1:0]   x_next;
	quad_t                  q_next;
	logic [SQ_W:0]          sq_rnd;

	logic signed [RW-2:0]   r_s1;
	logic signed [AX_W:0]   x_s2;
	quad_t                  q_s2;
	logic [AX_W-1:0]        ax_s3;
	logic                   neg_s3;
	quad_t                  q_s3;
	logic [SQ_W-1:0]        sq_s4;
	logic [AX_W-1:0]        ax_s4;
	logic                   neg_s4;
	quad_t                  q_s4;

	// Per-step registers: index 0 is the series seed, k is Taylor term k
	logic [T_W-1:0]         t_sin_sb [0:NSTEP];
	logic [T_W-1:0]         t_cos_sb [0:NSTEP];
	side_t                  side_sb  [0:NSTEP];
	logic [N_W-1:0]         n_sin_sa [1:NSTEP];
	logic [N_W-1:0]         n_cos_sa [1:NSTEP];
	logic signed [ACC_W-1:0] acc_sin_sa [1:NSTEP];
	logic signed [ACC_W-1:0] acc_cos_sa [1:NSTEP];
	logic signed [ACC_W-1:0] acc_sin_sb [1:NSTEP];
	logic signed [ACC_W-1:0] acc_cos_sb [1:NSTEP];
	side_t                  side_sa  [1:NSTEP];

	logic signed [ACC_W-1:0] sin_s18, cos_s18;
	logic                   neg_s18;
	quad_t                  q_s18;
	logic signed [ACC_W-1:0] sin_s19, cos_s19;
	quad_t                  q_s19;
	logic signed [ACC_W-1:0] sin_s20, cos_s20;

	// s1: one wrap into [-pi, pi]
	assign ang_q30 = RW'(ang) <<< Q30_SH;

	always_comb begin
		if (ang_q30 > PI_Q30) begin
			r_next = ang_q30 - TWO_PI_Q30;
		end else if (ang_q30 < -PI_Q30) begin
			r_next = ang_q30 + TWO_PI_Q30;
		end else begin
			r_next = ang_q30;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_next[RW-2:0];
	end

	// s2: quadrant and reduced angle in about +-pi/4
	assign r_w = RW'(r_s1);

	always_comb begin
		if (r_w > QTR_PI_Q30) begin
			if (r_w > TQTR_PI_Q30) begin
				x_next = r_w - (HALF_PI_Q30 <<< 1);
				q_next = QD_HALF;
			end else begin
				x_next = r_w - HALF_PI_Q30;
				q_next = QD_POS1;
			end
		end else if (r_w < -QTR_PI_Q30) begin
			if (r_w < -TQTR_PI_Q30) begin
				x_next = r_w + (HALF_PI_Q30 <<< 1);
				q_next = QD_HALF;
			end else begin
				x_next = r_w + HALF_PI_Q30;
				q_next = QD_NEG1;
			end
		end else begin
			x_next = r_w;
			q_next = QD_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		x_s2 <= x_next[AX_W:0];
		q_s2 <= q_next;
	end

	// s3: magnitude and sign
	always_ff @(posedge clk) begin
		ax_s3  <= x_s2[AX_W] ? AX_W'(-x_s2) : AX_W'(x_s2);
		neg_s3 <= x_s2[AX_W];
		q_s3   <= q_s2;
	end

	// s4: square
	always_ff @(posedge clk) begin
		sq_s4  <= ax_s3 * ax_s3;
		ax_s4  <= ax_s3;
		neg_s4 <= neg_s3;
		q_s4   <= q_s3;
	end

	// s5: square rounded to Q30, seed both series
	assign sq_rnd = {1'b0, sq_s4} + SQ_HALF;

	always_ff @(posedge clk) begin
		t_sin_sb[0]    <= T_W'(ax_s4);
		t_cos_sb[0]    <= ONE_Q30;
		side_sb[0].neg <= neg_s4;
		side_sb[0].q   <= q_s4;
		side_sb[0].x2  <= sq_rnd[SQ_W-1:SC_FRAC];
	end

	// Taylor terms: stage A multiplies by x^2, stage B divides by the constant
	genvar k;
	generate
		for (k = 1; k <= NSTEP; k++) begin : g_step
			localparam int SH    = STEP_SH[k-1];
			localparam int SOD   = SIN_ODD[k-1];
			localparam int COD   = COS_ODD[k-1];
			localparam int S_SIN = N_W + $clog2(SOD);
			localparam int S_COS = N_W + $clog2(COD);
			localparam logic [M_W-1:0] M_SIN = M_W'(((64'd1 << S_SIN) + SOD - 1) / SOD);
			localparam logic [M_W-1:0] M_COS = M_W'(((64'd1 << S_COS) + COD - 1) / COD);

			logic [PR_W-1:0] pr_sin, pr_cos;
			logic [QM_W-1:0] qm_sin, qm_cos;

			assign pr_sin = PR_W'(t_sin_sb[k-1]) * PR_W'(side_sb[k-1].x2);
			assign pr_cos = PR_W'(t_cos_sb[k-1]) * PR_W'(side_sb[k-1].x2);

			always_ff @(posedge clk) begin
				n_sin_sa[k] <= pr_sin[SC_FRAC+SH +: N_W];
				n_cos_sa[k] <= pr_cos[SC_FRAC+SH +: N_W];
				side_sa[k]  <= side_sb[k-1];
			end

			// fold the previous term into the running sums
			if (k == 1) begin : g_first
				always_ff @(posedge clk) begin
					acc_sin_sa[k] <= $signed(ACC_W'(t_sin_sb[k-1]));
					acc_cos_sa[k] <= $signed(ACC_W'(t_cos_sb[k-1]));
				end
			end else if ((k - 1) % 2 == 1) begin : g_sub
				always_ff @(posedge clk) begin
					acc_sin_sa[k] <= acc_sin_sb[k-1] - $signed(ACC_W'(t_sin_sb[k-1]));
					acc_cos_sa[k] <= acc_cos_sb[k-1] - $signed(ACC_W'(t_cos_sb[k-1]));
				end
			end else begin : g_add
				always_ff @(posedge clk) begin
					acc_sin_sa[k] <= acc_sin_sb[k-1] + $signed(ACC_W'(t_sin_sb[k-1]));
					acc_cos_sa[k] <= acc_cos_sb[k-1] + $signed(ACC_W'(t_cos_sb[k-1]));
				end
			end

			assign qm_sin = QM_W'(n_sin_sa[k]) * QM_W'(M_SIN);
			assign qm_cos = QM_W'(n_cos_sa[k]) * QM_W'(M_COS);

			always_ff @(posedge clk) begin
				t_sin_sb[k]   <= T_W'(qm_sin >> S_SIN);
				t_cos_sb[k]   <= T_W'(qm_cos >> S_COS);
				acc_sin_sb[k] <= acc_sin_sa[k];
				acc_cos_sb[k] <= acc_cos_sa[k];
				side_sb[k]    <= side_sa[k];
			end
		end
	endgenerate

	// s18: last term (even index, added)
	always_ff @(posedge clk) begin
		sin_s18 <= acc_sin_sb[NSTEP] + $signed(ACC_W'(t_sin_sb[NSTEP]));
		cos_s18 <= acc_cos_sb[NSTEP] + $signed(ACC_W'(t_cos_sb[NSTEP]));
		neg_s18 <= side_sb[NSTEP].neg;
		q_s18   <= side_sb[NSTEP].q;
	end

	// s19: odd symmetry of sine
	always_ff @(posedge clk) begin
		sin_s19 <= neg_s18 ? -sin_s18 : sin_s18;
		cos_s19 <= cos_s18;
		q_s19   <= q_s18;
	end

	// s20: undo the quarter-turn reduction
	always_ff @(posedge clk) begin
		case (q_s19)
			QD_POS1: begin
				sin_s20 <= cos_s19;
				cos_s20 <= -sin_s19;
			end
			QD_NEG1: begin
				sin_s20 <= -cos_s19;
				cos_s20 <= sin_s19;
			end
			QD_HALF: begin
				sin_s20 <= -sin_s19;
				cos_s20 <= -cos_s19;
			end
			default: begin
				sin_s20 <= sin_s19;
				cos_s20 <= cos_s19;
			end
		endcase
	end

	assign sin_q30 = sin_s20;
	assign cos_q30 = cos_s20;

endmodule

// File: rtl/camera_basis_from_yaw_pitch_top.sv
// ----------------------------------------------------------------------------
// camera_basis_from_yaw_pitch_top
// Wraps yaw, clamps pitch and returns the forward, right and up camera
// vectors in Q1.14 from a pipelined sine / cosine per angle.
// ----------------------------------------------------------------------------
//  channel  | strobe / hold  | payload
//  ---------+----------------+------------------------------------------------
//  command  | start / busy   | yaw_in, pitch_in
//  result   | done           | yaw_out, pitch_out, fwd_*, right_*, up_*
//
//  One item may be issued every cycle; busy is always low.
//  Between start and done an item passes through the input register, 20
//  sine / cosine stages (twelve of them for the Taylor terms) and four
//  stages for the products, sign split, rounding and sign restore.
//  Reset clears only the valid pipeline; payload registers are not reset.
//  done lasts one cycle per item and cannot be held off.
// ----------------------------------------------------------------------------
module camera_basis_from_yaw_pitch_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [cbyp_pkg::ANGLE_W-1:0] yaw_in,
	input  logic signed [cbyp_pkg::ANGLE_W-1:0] pitch_in,
	output logic                                done,
	output logic signed [cbyp_pkg::ANGLE_W-1:0] yaw_out,
	output logic signed [cbyp_pkg::PITCH_W-1:0] pitch_out,
	output logic signed [cbyp_pkg::VEC_W-1:0]   fwd_x,
	output logic signed [cbyp_pkg::VEC_W-1:0]   fwd_y,
	output logic signed [cbyp_pkg::VEC_W-1:0]   fwd_z,
	output logic signed [cbyp_pkg::VEC_W-1:0]   right_x,
	output logic signed [cbyp_pkg::VEC_W-1:0]   right_y,
	output logic signed [cbyp_pkg::VEC_W-1:0]   up_x,
	output logic signed [cbyp_pkg::VEC_W-1:0]   up_y,
	output logic signed [cbyp_pkg::VEC_W-1:0]   up_z
);
	import cbyp_pkg::*;

	localparam int LAT    = 1 + SC_LAT + 4;
	localparam int NLANE  = 8;
	localparam int LANE_W = 2 * SC_W;
	localparam int MAG_W  = 61;
	localparam int RND_SH = 2 * SC_FRAC - VEC_FRAC;
	localparam logic [MAG_W:0] RND_HALF = 62'd1 << (RND_SH - 1);

	// lane order
	localparam int L_FX = 0;
	localparam int L_FY = 1;
	localparam int L_FZ = 2;
	localparam int L_RX = 3;
	localparam int L_RY = 4;
	localparam int L_UX = 5;
	localparam int L_UY = 6;
	localparam int L_UZ = 7;

	logic                       accept;
	logic signed [ANGLE_XW-1:0] yaw_ext, yaw_wrap;
	logic signed [ANGLE_W-1:0]  pitch_clamp;

	logic [LAT-1:0]             vld_s;
	logic signed [ANGLE_W-1:0]  yaw_s   [1:LAT];
	logic signed [PITCH_W-1:0]  pitch_s [1:LAT];

	logic signed [SC_W-1:0]     sy, cy, sp, cp;

	logic signed [LANE_W-1:0]   lane_next [NLANE];
	logic signed [LANE_W-1:0]   lane_s22  [NLANE];
	logic [MAG_W-1:0]           mag_s23   [NLANE];
	logic                       neg_s23   [NLANE];
	logic [MAG_W:0]             rsum      [NLANE];
	logic [VEC_W-1:0]           rsh       [NLANE];
	logic [VEC_W-2:0]           rm_s24    [NLANE];
	logic                       neg_s24   [NLANE];
	logic signed [VEC_W-1:0]    vec_s25   [NLANE];

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Single yaw wrap and pitch clamp ahead of the input register
	assign yaw_ext = ANGLE_XW'(yaw_in);

	always_comb begin
		if (yaw_ext > PI_A) begin
			yaw_wrap = yaw_ext - TWO_PI_A;
		end else if (yaw_ext < -PI_A) begin
			yaw_wrap = yaw_ext + TWO_PI_A;
		end else begin
			yaw_wrap = yaw_ext;
		end
	end

	always_comb begin
		if (ANGLE_XW'(pitch_in) > PITCH_LIM_A) begin
			pitch_clamp = ANGLE_W'(PITCH_LIM_A);
		end else if (ANGLE_XW'(pitch_in) < -PITCH_LIM_A) begin
			pitch_clamp = ANGLE_W'(-PITCH_LIM_A);
		end else begin
			pitch_clamp = pitch_in;
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	// Angle registers and their delay line to the output
	always_ff @(posedge clk) begin
		yaw_s[1]   <= yaw_wrap[ANGLE_W-1:0];
		pitch_s[1] <= pitch_clamp[PITCH_W-1:0];
		for (int i = 2; i <= LAT; i++) begin
			yaw_s[i]   <= yaw_s[i-1];
			pitch_s[i] <= pitch_s[i-1];
		end
	end

	// Sine and cosine of both angles
	cbyp_sincos u_sc_yaw (
		.clk     (clk),
		.ang     (yaw_s[1]),
		.sin_q30 (sy),
		.cos_q30 (cy)
	);

	cbyp_sincos u_sc_pitch (
		.clk     (clk),
		.ang     (ANGLE_W'(pitch_s[1])),
		.sin_q30 (sp),
		.cos_q30 (cp)
	);

	// s22: products in Q60; single terms lifted to Q60
	always_comb begin
		lane_next[L_FX] = cy * cp;
		lane_next[L_FY] = sy * cp;
		lane_next[L_FZ] = -(LANE_W'(sp) <<< SC_FRAC);
		lane_next[L_RX] = LANE_W'(sy) <<< SC_FRAC;
		lane_next[L_RY] = -(LANE_W'(cy) <<< SC_FRAC);
		lane_next[L_UX] = cy * sp;
		lane_next[L_UY] = sy * sp;
		lane_next[L_UZ] = LANE_W'(cp) <<< SC_FRAC;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			lane_s22[i] <= lane_next[i];
		end
	end

	// s23: sign and magnitude
	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			neg_s23[i] <= lane_s22[i][LANE_W-1];
			mag_s23[i] <= lane_s22[i][LANE_W-1] ? MAG_W'(-lane_s22[i])
			                                    : MAG_W'(lane_s22[i]);
		end
	end

	// s24: round half away from zero, saturate to one
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			rsum[i] = {1'b0, mag_s23[i]} + RND_HALF;
			rsh[i]  = VEC_W'(rsum[i] >> RND_SH);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			neg_s24[i] <= neg_s23[i];
			rm_s24[i]  <= (rsh[i] > VEC_W'(VEC_ONE)) ? VEC_ONE : rsh[i][VEC_W-2:0];
		end
	end

	// s25: restore sign
	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			vec_s25[i] <= neg_s24[i] ? -$signed({1'b0, rm_s24[i]})
			                         : $signed({1'b0, rm_s24[i]});
		end
	end

	assign done      = vld_s[LAT-1];
	assign yaw_out   = yaw_s[LAT];
	assign pitch_out = pitch_s[LAT];
	assign fwd_x     = vec_s25[L_FX];
	assign fwd_y     = vec_s25[L_FY];
	assign fwd_z     = vec_s25[L_FZ];
	assign right_x   = vec_s25[L_RX];
	assign right_y   = vec_s25[L_RY];
	assign up_x      = vec_s25[L_UX];
	assign up_y      = vec_s25[L_UY];
	assign up_z      = vec_s25[L_UZ];

	// Checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT) done)
		else $error("result strobe missing after fixed latency");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (yaw_out <= PI_A && yaw_out >= -PI_A))
		else $error("wrapped yaw outside +-pi");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_out <= PITCH_LIM_A && pitch_out >= -PITCH_LIM_A))
		else $error("pitch outside clamp limits");

	a_up_z_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (up_z > 0))
		else $error("up vector z not positive for clamped pitch");

endmodule
